/* sv/encoder_period_tachometer_defines.svh */
// Assertion macros shared by the tachometer checker.
`ifndef ENCODER_PERIOD_TACHOMETER_DEFINES_SVH
`define ENCODER_PERIOD_TACHOMETER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define EPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define EPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ept_pkg.sv */
// Shared types and constants for the encoder period tachometer.
package ept_pkg;

  localparam int DIVIDEND_W = 32;
  localparam int CNT_W      = $clog2(DIVIDEND_W);
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] ALPHA_RST   = 16'd32768;
  localparam logic [7:0]  EPC_RST     = 8'd10;
  localparam logic [31:0] TIMEOUT_RST = 32'd200000;
  localparam logic [23:0] NUMER_RST   = 24'd15000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA   = 2'd0,
    CFG_EPC     = 2'd1,
    CFG_TIMEOUT = 2'd2,
    CFG_NUMER   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic accept;    // word taken: advance time, count the edge
    logic load_div;  // word carries a read: set up the divider
    logic div_step;  // one quotient bit
    logic mul;       // filter products
    logic sum;       // filter update
    logic push;      // move filter value into the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

/* sv/encoder_period_tachometer.sv */
// Encoder period tachometer top level: sequencer plus datapath.
// Each input word is one tick. A word without a read request is taken without
// a stall and the next word can follow at once. A word with a read request
// occupies the block through its acceptance, 32 steps of the one-bit-per-cycle
// restoring divider that forms numerator*256/period, the two filter products,
// the filter sum and the load of the output register. That last step waits
// while a previous result still sits stalled in the output register.
// Configuration writes take effect at the clock edge where cfg_we is high.
module encoder_period_tachometer
  import ept_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_edge_req,
  input  logic                  in_read_request,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_speed_rpm_q8
);

  cmd_t cmd;
  sts_t sts;

  ept_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_read_request (in_read_request),
    .in_stall        (in_stall),
    .sts             (sts),
    .cmd             (cmd)
  );

  ept_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_edge_req      (in_edge_req),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_speed_rpm_q8 (out_speed_rpm_q8),
    .out_stall        (out_stall)
  );

endmodule

/* sv/ept_ctrl.sv */
// Sequencer for the tachometer: takes words and steps the datapath through a read.
module ept_ctrl
  import ept_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_read_request,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_PUSH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && in_read_request) begin
          cmd.load_div = 1'b1;
          cnt_nxt      = CNT_W'(DIVIDEND_W - 1);
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* sv/ept_datapath.sv */
// Tachometer datapath: time base, edge capture, divider, filter and output register.
module ept_datapath
  import ept_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_edge_req,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_speed_rpm_q8,
  input  logic                  out_stall
);

  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [15:0] alpha_r;
  logic [7:0]  epc_r;
  logic [31:0] timeout_r;
  logic [23:0] numer_r;

  logic [TIME_BITS-1:0] time_r, last_r, period_r;
  logic [7:0]           edge_cnt_r;
  logic [OUT_W-1:0]     filt_r;

  logic [TIME_BITS-1:0]  rem_r, dvsr_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic                  mzero_r;
  logic [47:0]           prod_a_r;
  logic [48:0]           prod_b_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  logic [7:0]            edge_cnt_inc;
  logic                  capture;
  logic [TIME_BITS-1:0]  elapsed, period_edge, period_rd;
  logic                  timed_out;
  logic [TIME_BITS:0]    rem_shift;
  logic [TIME_BITS+1:0]  diff;
  logic [DIVIDEND_W-1:0] meas;
  logic [16:0]           beta;
  logic [49:0]           acc;

  assign edge_cnt_inc = edge_cnt_r + 8'd1;
  // A count of zero in the register still captures on every edge.
  assign capture      = in_edge_req && (edge_cnt_inc >= epc_r);
  assign period_edge  = capture ? (time_r - last_r) : period_r;
  // After a capture in the same tick the elapsed time is zero.
  assign elapsed      = capture ? '0 : (time_r - last_r);
  assign timed_out    = CMP_W'(elapsed) > CMP_W'(timeout_r);
  assign period_rd    = timed_out ? '0 : period_edge;

  // Restoring division, one quotient bit per step.
  assign rem_shift = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvsr_r};

  assign meas = mzero_r ? '0 : quo_r;
  assign beta = 17'h10000 - {1'b0, alpha_r};
  assign acc  = 50'(prod_a_r) + 50'(prod_b_r);

  assign sts.out_free     = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_speed_rpm_q8 = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ALPHA_RST;
      epc_r       <= EPC_RST;
      timeout_r   <= TIMEOUT_RST;
      numer_r     <= NUMER_RST;
      time_r      <= '0;
      last_r      <= '0;
      period_r    <= '0;
      edge_cnt_r  <= '0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALPHA:   alpha_r   <= cfg_wdata[15:0];
          CFG_EPC:     epc_r     <= cfg_wdata[7:0];
          CFG_TIMEOUT: timeout_r <= cfg_wdata[31:0];
          CFG_NUMER:   numer_r   <= cfg_wdata[23:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        time_r <= time_r + 1'b1;
        if (in_edge_req) begin
          edge_cnt_r <= capture ? 8'd0 : edge_cnt_inc;
        end
        if (capture) begin
          last_r <= time_r;
        end
        period_r <= cmd.load_div ? period_rd : period_edge;
      end
      if (cmd.sum) begin
        filt_r <= acc[47:16];
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      rem_r   <= '0;
      quo_r   <= {numer_r, 8'd0};
      dvsr_r  <= period_rd;
      mzero_r <= (period_rd == '0);
    end else if (cmd.div_step) begin
      rem_r <= diff[TIME_BITS+1] ? rem_shift[TIME_BITS-1:0] : diff[TIME_BITS-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], ~diff[TIME_BITS+1]};
    end
    if (cmd.mul) begin
      prod_a_r <= 48'(alpha_r) * 48'(filt_r);
      prod_b_r <= 49'(beta) * 49'(meas);
    end
    if (cmd.push) begin
      out_data_r <= filt_r;
    end
  end

endmodule

/* sv/ept_checker.sv */
// Port-level checks for the encoder period tachometer, bound to the top level.
`include "encoder_period_tachometer_defines.svh"

module ept_checker
  import ept_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_read_request,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] out_speed_rpm_q8
);

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  // A read keeps the block busy while the divider runs.
  `EPT_ASSERT_NEXT(a_read_busy, in_acc && in_read_request, in_stall, "read word not held off")
  // A word without a read finishes in its own cycle.
  `EPT_ASSERT_NEXT(a_plain_fast, in_acc && !in_read_request, !in_stall, "plain word stalled")
  // A new result only appears at the end of a read.
  `EPT_ASSERT_SAME(a_out_from_read, $rose(out_valid), $past(in_stall), "result without read")
  `EPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_speed_rpm_q8), "stalled result changed")

endmodule

bind encoder_period_tachometer ept_checker u_ept_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_read_request  (in_read_request),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_speed_rpm_q8 (out_speed_rpm_q8)
);
